/* rtl/lav_pkg.sv */
// Shared constants for the look-at view matrix unit.
// Depends on nothing; imported by lav_norm and look_at_view_matrix_unit.
package lav_pkg;

   // Normalised magnitudes carry this many bits above the axis fraction
   localparam int NORM_HEAD_BITS = 4;

   // Integer bits of an axis component, sign included (Q2.x)
   localparam int AXIS_INT_BITS = 2;

endpackage

/* rtl/look_at_view_matrix_unit.sv */
// Look-at view matrix unit: top level pipeline with three normalisers.
// Depends on lav_pkg and lav_norm.
//
//   channel   ports                          transfer
//   request   start, busy, req_eye/aim/upward start high while busy low
//   response  rsp_valid, rsp_m00 .. rsp_m23   rsp_valid high for one cycle
//
// One transfer is taken every cycle; busy stays low.
// rsp_valid rises once the transfer has passed the root and divide stages of the
// three normalisers, each of which resolves one bit per stage.
// Synchronous reset clears only the valid bits; data registers are not reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module look_at_view_matrix_unit #(
   parameter int COORD_WIDTH    = 32,
   parameter int AXIS_FRAC_BITS = 30
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    start,
   output logic                                                    busy,
   input  logic signed [COORD_WIDTH-1:0]                           req_eye_x,
   input  logic signed [COORD_WIDTH-1:0]                           req_eye_y,
   input  logic signed [COORD_WIDTH-1:0]                           req_eye_z,
   input  logic signed [COORD_WIDTH-1:0]                           req_aim_x,
   input  logic signed [COORD_WIDTH-1:0]                           req_aim_y,
   input  logic signed [COORD_WIDTH-1:0]                           req_aim_z,
   input  logic signed [COORD_WIDTH-1:0]                           req_upward_x,
   input  logic signed [COORD_WIDTH-1:0]                           req_upward_y,
   input  logic signed [COORD_WIDTH-1:0]                           req_upward_z,
   output logic                                                    rsp_valid,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m00,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m01,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m02,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m10,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m11,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m12,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m20,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m21,
   output logic signed [AXIS_FRAC_BITS+lav_pkg::AXIS_INT_BITS-1:0] rsp_m22,
   output logic signed [COORD_WIDTH+1:0]                           rsp_m03,
   output logic signed [COORD_WIDTH+1:0]                           rsp_m13,
   output logic signed [COORD_WIDTH+1:0]                           rsp_m23
);
   import lav_pkg::*;

   localparam int CW      = COORD_WIDTH;
   localparam int FRAC    = AXIS_FRAC_BITS;
   localparam int AW      = FRAC + AXIS_INT_BITS;
   localparam int CP_W    = CW + AW;
   localparam int FP_W    = 2 * AW;
   localparam int TP_W    = AW + CW;
   localparam int SW      = TP_W + 2;
   localparam int TW      = CW + 2;
   localparam int SIDE1_W = 6 * CW;
   localparam int SIDE2_W = 3 * CW + 3 * AW;
   localparam int SIDE3_W = 3 * CW + 6 * AW;

   // The pipeline never holds, so a transfer is taken in every cycle
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // T0: capture the transfer
   // ---------------------------------------------------------------
   logic                 v0_ff;
   logic signed [CW-1:0] eye0_ff [3];
   logic signed [CW-1:0] aim0_ff [3];
   logic signed [CW-1:0] up0_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      eye0_ff <= '{req_eye_x, req_eye_y, req_eye_z};
      aim0_ff <= '{req_aim_x, req_aim_y, req_aim_z};
      up0_ff  <= '{req_upward_x, req_upward_y, req_upward_z};
   end

   // ---------------------------------------------------------------
   // T1: forward direction eye - aim as sign and magnitude
   // ---------------------------------------------------------------
   logic signed [CW:0]   d1_in    [3];
   logic signed [CW:0]   dn1_in   [3];
   logic [SIDE1_W-1:0]   side1_in;
   logic                 v1_ff;
   logic [CW:0]          dmag1_ff [3];
   logic [2:0]           dneg1_ff;
   logic [SIDE1_W-1:0]   side1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i]  = {eye0_ff[i][CW-1], eye0_ff[i]} - {aim0_ff[i][CW-1], aim0_ff[i]};
         dn1_in[i] = -d1_in[i];
         side1_in[i*CW +: CW]     = eye0_ff[i];
         side1_in[(3+i)*CW +: CW] = up0_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dmag1_ff[i] <= d1_in[i][CW] ? dn1_in[i] : d1_in[i];
         dneg1_ff[i] <= d1_in[i][CW];
      end
      side1_ff <= side1_in;
   end

   // ---------------------------------------------------------------
   // Forward axis
   // ---------------------------------------------------------------
   logic                 fwd_v;
   logic signed [AW-1:0] fwd_axis [3];
   logic [SIDE1_W-1:0]   fwd_side;

   lav_norm #(
      .MAG_W  (CW + 1),
      .FRAC   (FRAC),
      .SIDE_W (SIDE1_W)
   ) u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_mag    (dmag1_ff),
      .in_neg    (dneg1_ff),
      .in_side   (side1_ff),
      .out_valid (fwd_v),
      .out_axis  (fwd_axis),
      .out_side  (fwd_side)
   );

   // ---------------------------------------------------------------
   // T2: products of up hint cross forward
   // ---------------------------------------------------------------
   logic signed [CW-1:0]   up2_in  [3];
   logic [SIDE2_W-1:0]     side2_in;
   logic                   v2_ff;
   logic signed [CP_W-1:0] pa2_ff  [3];
   logic signed [CP_W-1:0] pb2_ff  [3];
   logic [SIDE2_W-1:0]     side2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         up2_in[i] = fwd_side[(3+i)*CW +: CW];
         side2_in[i*CW +: CW]          = fwd_side[i*CW +: CW];
         side2_in[3*CW + i*AW +: AW]   = fwd_axis[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= fwd_v;
      end
   end

   always_ff @(posedge clock) begin
      pa2_ff[0] <= CP_W'(up2_in[1]) * CP_W'(fwd_axis[2]);
      pb2_ff[0] <= CP_W'(up2_in[2]) * CP_W'(fwd_axis[1]);
      pa2_ff[1] <= CP_W'(up2_in[2]) * CP_W'(fwd_axis[0]);
      pb2_ff[1] <= CP_W'(up2_in[0]) * CP_W'(fwd_axis[2]);
      pa2_ff[2] <= CP_W'(up2_in[0]) * CP_W'(fwd_axis[1]);
      pb2_ff[2] <= CP_W'(up2_in[1]) * CP_W'(fwd_axis[0]);
      side2_ff  <= side2_in;
   end

   // ---------------------------------------------------------------
   // T3: right direction as sign and magnitude
   // ---------------------------------------------------------------
   logic signed [CP_W-1:0] c3_in  [3];
   logic signed [CP_W-1:0] cn3_in [3];
   logic                   v3_ff;
   logic [CP_W-2:0]        cmag3_ff [3];
   logic [2:0]             cneg3_ff;
   logic [SIDE2_W-1:0]     side3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c3_in[i]  = pa2_ff[i] - pb2_ff[i];
         cn3_in[i] = -c3_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         cmag3_ff[i] <= c3_in[i][CP_W-1] ? cn3_in[i][CP_W-2:0] : c3_in[i][CP_W-2:0];
         cneg3_ff[i] <= c3_in[i][CP_W-1];
      end
      side3_ff <= side2_ff;
   end

   // ---------------------------------------------------------------
   // Right axis
   // ---------------------------------------------------------------
   logic                 rgt_v;
   logic signed [AW-1:0] rgt_axis [3];
   logic [SIDE2_W-1:0]   rgt_side;

   lav_norm #(
      .MAG_W  (CP_W - 1),
      .FRAC   (FRAC),
      .SIDE_W (SIDE2_W)
   ) u_norm_rgt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_mag    (cmag3_ff),
      .in_neg    (cneg3_ff),
      .in_side   (side3_ff),
      .out_valid (rgt_v),
      .out_axis  (rgt_axis),
      .out_side  (rgt_side)
   );

   // ---------------------------------------------------------------
   // T4: products of forward cross right
   // ---------------------------------------------------------------
   logic signed [AW-1:0]   fwd4_in [3];
   logic [SIDE3_W-1:0]     side4_in;
   logic                   v4_ff;
   logic signed [FP_W-1:0] pa4_ff  [3];
   logic signed [FP_W-1:0] pb4_ff  [3];
   logic [SIDE3_W-1:0]     side4_ff;

   always_comb begin
      side4_in = {{(3*AW){1'b0}}, rgt_side};
      for (int i = 0; i < 3; i++) begin
         fwd4_in[i] = rgt_side[3*CW + i*AW +: AW];
         side4_in[3*CW + 3*AW + i*AW +: AW] = rgt_axis[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= rgt_v;
      end
   end

   always_ff @(posedge clock) begin
      pa4_ff[0] <= FP_W'(fwd4_in[1]) * FP_W'(rgt_axis[2]);
      pb4_ff[0] <= FP_W'(fwd4_in[2]) * FP_W'(rgt_axis[1]);
      pa4_ff[1] <= FP_W'(fwd4_in[2]) * FP_W'(rgt_axis[0]);
      pb4_ff[1] <= FP_W'(fwd4_in[0]) * FP_W'(rgt_axis[2]);
      pa4_ff[2] <= FP_W'(fwd4_in[0]) * FP_W'(rgt_axis[1]);
      pb4_ff[2] <= FP_W'(fwd4_in[1]) * FP_W'(rgt_axis[0]);
      side4_ff  <= side4_in;
   end

   // ---------------------------------------------------------------
   // T5: true up direction as sign and magnitude
   // ---------------------------------------------------------------
   logic signed [FP_W-1:0] c5_in  [3];
   logic signed [FP_W-1:0] cn5_in [3];
   logic                   v5_ff;
   logic [FP_W-2:0]        cmag5_ff [3];
   logic [2:0]             cneg5_ff;
   logic [SIDE3_W-1:0]     side5_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c5_in[i]  = pa4_ff[i] - pb4_ff[i];
         cn5_in[i] = -c5_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         cmag5_ff[i] <= c5_in[i][FP_W-1] ? cn5_in[i][FP_W-2:0] : c5_in[i][FP_W-2:0];
         cneg5_ff[i] <= c5_in[i][FP_W-1];
      end
      side5_ff <= side4_ff;
   end

   // ---------------------------------------------------------------
   // True up axis
   // ---------------------------------------------------------------
   logic                 tup_v;
   logic signed [AW-1:0] tup_axis [3];
   logic [SIDE3_W-1:0]   tup_side;

   lav_norm #(
      .MAG_W  (FP_W - 1),
      .FRAC   (FRAC),
      .SIDE_W (SIDE3_W)
   ) u_norm_tup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_mag    (cmag5_ff),
      .in_neg    (cneg5_ff),
      .in_side   (side5_ff),
      .out_valid (tup_v),
      .out_axis  (tup_axis),
      .out_side  (tup_side)
   );

   // ---------------------------------------------------------------
   // T6: assemble rows, multiply each by the eye position
   // ---------------------------------------------------------------
   logic signed [AW-1:0]   rows6_in [3][3];
   logic signed [CW-1:0]   eye6_in  [3];
   logic                   v6_ff;
   logic signed [AW-1:0]   rows6_ff [3][3];
   logic signed [TP_W-1:0] tp6_ff   [3][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         eye6_in[j]     = tup_side[j*CW +: CW];
         rows6_in[0][j] = tup_side[3*CW + 3*AW + j*AW +: AW];
         rows6_in[1][j] = tup_axis[j];
         rows6_in[2][j] = tup_side[3*CW + j*AW +: AW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= tup_v;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            tp6_ff[i][j] <= TP_W'(rows6_in[i][j]) * TP_W'(eye6_in[j]);
         end
      end
      rows6_ff <= rows6_in;
   end

   // ---------------------------------------------------------------
   // T7: dot products
   // ---------------------------------------------------------------
   logic                 v7_ff;
   logic signed [SW-1:0] acc7_ff  [3];
   logic signed [AW-1:0] rows7_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         acc7_ff[i] <= SW'(tp6_ff[i][0]) + SW'(tp6_ff[i][1]) + SW'(tp6_ff[i][2]);
      end
      rows7_ff <= rows6_ff;
   end

   // ---------------------------------------------------------------
   // T8: round half away from zero to an integer, negate
   // ---------------------------------------------------------------
   logic [SW-1:0]        amag8_in [3];
   logic signed [SW-1:0] aneg8_in [3];
   logic [SW:0]          rnd8_in  [3];
   logic [SW:0]          mq8_in   [3];
   logic [SW:0]          tr8_in   [3];
   logic                 rsp_valid_ff;
   logic signed [TW-1:0] trans_ff [3];
   logic signed [AW-1:0] rows8_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         aneg8_in[i] = -acc7_ff[i];
         amag8_in[i] = acc7_ff[i][SW-1] ? aneg8_in[i] : acc7_ff[i];
         rnd8_in[i]  = {1'b0, amag8_in[i]} + ((SW+1)'(1) << (FRAC - 1));
         mq8_in[i]   = rnd8_in[i] >> FRAC;
         tr8_in[i]   = acc7_ff[i][SW-1] ? mq8_in[i] : -mq8_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         trans_ff[i] <= tr8_in[i][TW-1:0];
      end
      rows8_ff <= rows7_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_m00   = rows8_ff[0][0];
   assign rsp_m01   = rows8_ff[0][1];
   assign rsp_m02   = rows8_ff[0][2];
   assign rsp_m10   = rows8_ff[1][0];
   assign rsp_m11   = rows8_ff[1][1];
   assign rsp_m12   = rows8_ff[1][2];
   assign rsp_m20   = rows8_ff[2][0];
   assign rsp_m21   = rows8_ff[2][1];
   assign rsp_m22   = rows8_ff[2][2];
   assign rsp_m03   = trans_ff[0];
   assign rsp_m13   = trans_ff[1];
   assign rsp_m23   = trans_ff[2];

   // ---------------------------------------------------------------
   // Checks on degenerate cameras
   // ---------------------------------------------------------------
   a_fwd_zero_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_m20 == '0 && rsp_m21 == '0 && rsp_m22 == '0
      |-> rsp_m00 == '0 && rsp_m01 == '0 && rsp_m02 == '0)
      else $error("right axis not zero for a zero forward axis");

   a_right_zero_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_m00 == '0 && rsp_m01 == '0 && rsp_m02 == '0
      |-> rsp_m10 == '0 && rsp_m11 == '0 && rsp_m12 == '0
          && rsp_m03 == '0 && rsp_m13 == '0)
      else $error("true up axis or translation not zero for a zero right axis");

   a_fwd_zero_trans: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_m20 == '0 && rsp_m21 == '0 && rsp_m22 == '0
      |-> rsp_m23 == '0)
      else $error("forward translation not zero for a zero forward axis");

endmodule

/* rtl/lav_norm.sv */
// Pipelined 3-vector normaliser: leading-one search, shift, sum of squares,
// bit-per-stage square root and bit-per-stage divide. Depends on lav_pkg.
module lav_norm #(
   parameter int MAG_W  = 33,
   parameter int FRAC   = 30,
   parameter int SIDE_W = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [MAG_W-1:0]                              in_mag [3],
   input  logic [2:0]                                    in_neg,
   input  logic [SIDE_W-1:0]                             in_side,
   output logic                                          out_valid,
   output logic signed [FRAC+lav_pkg::AXIS_INT_BITS-1:0] out_axis [3],
   output logic [SIDE_W-1:0]                             out_side
);
   import lav_pkg::*;

   localparam int NB   = FRAC + NORM_HEAD_BITS;
   localparam int K    = NB + 1;
   localparam int RW   = K + 3;
   localparam int DW   = K + FRAC + 1;
   localparam int QW   = FRAC + 1;
   localparam int AW   = FRAC + AXIS_INT_BITS;
   localparam int LZ_W = $clog2(MAG_W);

   // ---------------------------------------------------------------
   // Stage 1: find the leading one over all three magnitudes
   // ---------------------------------------------------------------
   logic [MAG_W-1:0]  or_in;
   logic [LZ_W-1:0]   lz_in;
   logic              v1_ff;
   logic [MAG_W-1:0]  mag1_ff [3];
   logic [2:0]        neg1_ff;
   logic [LZ_W-1:0]   lz1_ff;
   logic              zero1_ff;
   logic [SIDE_W-1:0] side1_ff;

   always_comb begin
      or_in = in_mag[0] | in_mag[1] | in_mag[2];
      lz_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (or_in[i]) begin
            lz_in = LZ_W'(MAG_W - 1 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      mag1_ff  <= in_mag;
      neg1_ff  <= in_neg;
      lz1_ff   <= lz_in;
      zero1_ff <= (or_in == '0);
      side1_ff <= in_side;
   end

   // ---------------------------------------------------------------
   // Stage 2: bring the largest magnitude to NB bits (dropped low bits truncate)
   // ---------------------------------------------------------------
   logic [MAG_W+NB-1:0] sh_in [3];
   logic [NB-1:0]       c2_in [3];
   logic                v2_ff;
   logic [NB-1:0]       c2_ff [3];
   logic [2:0]          neg2_ff;
   logic                zero2_ff;
   logic [SIDE_W-1:0]   side2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh_in[i] = {mag1_ff[i], {NB{1'b0}}} << lz1_ff;
         c2_in[i] = sh_in[i][MAG_W+NB-1 -: NB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      c2_ff    <= c2_in;
      neg2_ff  <= neg1_ff;
      zero2_ff <= zero1_ff;
      side2_ff <= side1_ff;
   end

   // ---------------------------------------------------------------
   // Stage 3: square each component
   // ---------------------------------------------------------------
   logic                v3_ff;
   logic [2*NB-1:0]     sq3_ff [3];
   logic [NB-1:0]       c3_ff [3];
   logic [2:0]          neg3_ff;
   logic                zero3_ff;
   logic [SIDE_W-1:0]   side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq3_ff[i] <= {{NB{1'b0}}, c2_ff[i]} * {{NB{1'b0}}, c2_ff[i]};
      end
      c3_ff    <= c2_ff;
      neg3_ff  <= neg2_ff;
      zero3_ff <= zero2_ff;
      side3_ff <= side2_ff;
   end

   // ---------------------------------------------------------------
   // Stage 4: sum of squares, loaded into the root pipeline
   // ---------------------------------------------------------------
   logic [2*K-1:0]    sr_rad_ff  [0:K];
   logic [RW-1:0]     sr_rem_ff  [0:K];
   logic [K-1:0]      sr_root_ff [0:K];
   logic [NB-1:0]     sr_c_ff    [0:K][3];
   logic [2:0]        sr_neg_ff  [0:K];
   logic              sr_zero_ff [0:K];
   logic [SIDE_W-1:0] sr_side_ff [0:K];
   logic              sr_v_ff    [0:K];

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_v_ff[0] <= 1'b0;
      end else begin
         sr_v_ff[0] <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sr_rad_ff[0]  <= {2'b00, sq3_ff[0]} + {2'b00, sq3_ff[1]} + {2'b00, sq3_ff[2]};
      sr_rem_ff[0]  <= '0;
      sr_root_ff[0] <= '0;
      sr_c_ff[0]    <= c3_ff;
      sr_neg_ff[0]  <= neg3_ff;
      sr_zero_ff[0] <= zero3_ff;
      sr_side_ff[0] <= side3_ff;
   end

   // ---------------------------------------------------------------
   // Square root: one root bit per stage, restoring recurrence
   // ---------------------------------------------------------------
   for (genvar j = 0; j < K; j++) begin : g_sqrt
      localparam int BIT = K - 1 - j;
      logic [RW-1:0] rem_t;
      logic [RW-1:0] trial;
      logic          fits;

      always_comb begin
         rem_t = {sr_rem_ff[j][RW-3:0], sr_rad_ff[j][2*BIT+1 -: 2]};
         trial = {1'b0, sr_root_ff[j], 2'b01};
         fits  = (rem_t >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_v_ff[j+1] <= 1'b0;
         end else begin
            sr_v_ff[j+1] <= sr_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         sr_rad_ff[j+1]  <= sr_rad_ff[j];
         sr_rem_ff[j+1]  <= fits ? (rem_t - trial) : rem_t;
         sr_root_ff[j+1] <= {sr_root_ff[j][K-2:0], fits};
         sr_c_ff[j+1]    <= sr_c_ff[j];
         sr_neg_ff[j+1]  <= sr_neg_ff[j];
         sr_zero_ff[j+1] <= sr_zero_ff[j];
         sr_side_ff[j+1] <= sr_side_ff[j];
      end
   end

   // ---------------------------------------------------------------
   // Divider load: scale each component and add half the divisor
   // ---------------------------------------------------------------
   logic [DW-1:0]     dv_r_ff    [0:FRAC+1][3];
   logic [QW-1:0]     dv_q_ff    [0:FRAC+1][3];
   logic [K-1:0]      dv_n_ff    [0:FRAC+1];
   logic [2:0]        dv_neg_ff  [0:FRAC+1];
   logic              dv_zero_ff [0:FRAC+1];
   logic [SIDE_W-1:0] dv_side_ff [0:FRAC+1];
   logic              dv_v_ff    [0:FRAC+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else begin
         dv_v_ff[0] <= sr_v_ff[K];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dv_r_ff[0][i] <= (DW'(sr_c_ff[K][i]) << FRAC) + DW'(sr_root_ff[K] >> 1);
         dv_q_ff[0][i] <= '0;
      end
      dv_n_ff[0]    <= sr_root_ff[K];
      dv_neg_ff[0]  <= sr_neg_ff[K];
      dv_zero_ff[0] <= sr_zero_ff[K];
      dv_side_ff[0] <= sr_side_ff[K];
   end

   // ---------------------------------------------------------------
   // Divide: one quotient bit per stage for all three lanes
   // ---------------------------------------------------------------
   for (genvar j = 0; j <= FRAC; j++) begin : g_div
      localparam int BIT = FRAC - j;
      logic [DW-1:0] dvs;
      logic [DW-1:0] r_nx [3];
      logic [QW-1:0] q_nx [3];

      always_comb begin
         dvs = DW'(dv_n_ff[j]) << BIT;
         for (int i = 0; i < 3; i++) begin
            if (dv_r_ff[j][i] >= dvs) begin
               r_nx[i] = dv_r_ff[j][i] - dvs;
               q_nx[i] = dv_q_ff[j][i] | (QW'(1) << BIT);
            end else begin
               r_nx[i] = dv_r_ff[j][i];
               q_nx[i] = dv_q_ff[j][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         dv_r_ff[j+1]    <= r_nx;
         dv_q_ff[j+1]    <= q_nx;
         dv_n_ff[j+1]    <= dv_n_ff[j];
         dv_neg_ff[j+1]  <= dv_neg_ff[j];
         dv_zero_ff[j+1] <= dv_zero_ff[j];
         dv_side_ff[j+1] <= dv_side_ff[j];
      end
   end

   // ---------------------------------------------------------------
   // Output: restore signs, force a zero vector to zero
   // ---------------------------------------------------------------
   logic signed [AW-1:0] qs_in   [3];
   logic signed [AW-1:0] axis_in [3];
   logic                 out_valid_ff;
   logic signed [AW-1:0] axis_ff [3];
   logic [SIDE_W-1:0]    out_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qs_in[i] = $signed({1'b0, dv_q_ff[FRAC+1][i]});
         if (dv_zero_ff[FRAC+1]) begin
            axis_in[i] = '0;
         end else if (dv_neg_ff[FRAC+1][i]) begin
            axis_in[i] = -qs_in[i];
         end else begin
            axis_in[i] = qs_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_v_ff[FRAC+1];
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      out_side_ff <= dv_side_ff[FRAC+1];
   end

   assign out_valid = out_valid_ff;
   assign out_axis  = axis_ff;
   assign out_side  = out_side_ff;

endmodule
